@@ rtl/arq_retransmit_slot_table_unit_macros.svh @@
// Assertion macros for the slot table RTL, used by arqst_back.
`ifndef ARQ_RETRANSMIT_SLOT_TABLE_UNIT_MACROS_SVH
`define ARQ_RETRANSMIT_SLOT_TABLE_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ARQST_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arqst: same-cycle check failed");

// Next-cycle implication, checked on every rising clk edge outside reset.
`define ARQST_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arqst: next-cycle check failed");

`else

`define ARQST_ASSERT_IMPLIES(name, ante, cons)
`define ARQST_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ rtl/arqst_pkg.sv @@
// Types, codes and helper functions of the retransmit slot table.
package arqst_pkg;

  localparam int unsigned SEQ_W    = 8;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned CHUNK_W  = 4;
  localparam int unsigned OCC_W    = 9;

  // Clear results sent for a retransmit timeout on an empty slot.
  localparam logic [CHUNK_W-1:0] MISS_CLEARS = 4'd8;

  localparam logic [OCC_W-1:0] OCC_LIMIT_RESET = 9'd240;
  localparam logic [OCC_W-1:0] OCC_MAX         = 9'd511;

  // Register index, taken from paddr[2].
  localparam logic REG_OCC_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_ACK    = 2'd1,
    MODE_RETX   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } back_state_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    mode_t               mode;
    logic [SEQ_W-1:0]    seq;
    logic                in_table;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
    logic [CHUNK_W-1:0]  chunks;
  } cmd_t;

  // One slot of the table memory.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
    logic [CHUNK_W-1:0]  remaining;
    logic [CHUNK_W-1:0]  total;
  } entry_t;

  // One result item.
  typedef struct packed {
    kind_t               kind;
    logic                hit;
    logic                freed;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
    logic [SEQ_W-1:0]    chunk_seq;
    logic                room;
    logic                last;
  } res_t;

  function automatic logic [OCC_W-1:0] occ_dec(input logic [OCC_W-1:0] occ);
    occ_dec = (occ == '0) ? occ : occ - 9'd1;
  endfunction

  function automatic logic [OCC_W-1:0] occ_inc(input logic [OCC_W-1:0] occ);
    occ_inc = (occ == OCC_MAX) ? occ : occ + 9'd1;
  endfunction

endpackage

@@ rtl/arq_retransmit_slot_table_unit.sv @@
// Top level of the ARQ retransmit slot table: APB register, front, queue and back.
//
// Use: link events enter on s_axis as one item each; mode rides in s_axis_tuser,
// seq, buffer handle, length and chunk count in s_axis_tdata. Results leave on
// m_axis, one or more per item: kind in m_axis_tuser, the other fields in
// m_axis_tdata, and m_axis_tlast on the final result of each item.
// The first result of an item passes the command queue, the slot memory read
// and the result register before it shows on m_axis. A single-result item
// (insert, acknowledge, clear all) reads the slot memory in the back end, then
// updates the slot and loads the result register. A retransmit then sends its
// further results (up to nine results in all) from the single output register,
// one result per cycle while m_axis_tready stays high.
// Reset (synchronous, rst high) clears every slot valid bit at once, zeroes the
// occupancy and sets occupancy_limit to 240; no clearing pass is needed.
// When m_axis_tready is low the output register holds its result, the back end
// waits, and the two-entry command queue absorbs up to two more items before
// s_axis_tready drops. occupancy_limit lives at APB address 0; the user must
// write it only while the block is idle, as the block does not enforce this.
module arq_retransmit_slot_table_unit #(
  parameter int unsigned SLOTS       = 256,
  parameter int unsigned MAX_CHUNKS  = 8,
  parameter int unsigned MAX_MESSAGE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // seq[7:0], buffer_handle[39:8], length[50:40], chunk_count[54:51], zero[55]
  input  logic [55:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit[0], freed[1], resend_handle[33:2], resend_length[44:34],
  // chunk_seq[52:45], room_available[53], zero[55:54]
  output logic [55:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [arqst_pkg::OCC_W-1:0] occ_limit;
  logic                        q_full;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_valid;
  arqst_pkg::cmd_t             push_cmd;
  arqst_pkg::cmd_t             head_cmd;
  arqst_pkg::res_t             res;

  // APB register: the index sits in paddr[2], byte offset bits are ignored
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ_limit <= arqst_pkg::OCC_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == arqst_pkg::REG_OCC_LIMIT) begin
      occ_limit <= pwdata[arqst_pkg::OCC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == arqst_pkg::REG_OCC_LIMIT) prdata = {23'd0, occ_limit};
  end

  // decode and saturate incoming items
  arqst_front #(
    .SLOTS       (SLOTS),
    .MAX_CHUNKS  (MAX_CHUNKS),
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_front (
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // decouple acceptance from execution
  arqst_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (head_cmd)
  );

  // execute against the slot table and sequence the results
  arqst_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .occ_limit (occ_limit),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_res     (res)
  );

  // pack the result register onto the output bus
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {2'b00, res.room, res.chunk_seq, res.length, res.handle,
                         res.freed, res.hit};

endmodule

@@ rtl/arqst_front.sv @@
// Input side: unpack, saturate and classify each item into a command.
module arqst_front #(
  parameter int unsigned SLOTS       = 256,
  parameter int unsigned MAX_CHUNKS  = 8,
  parameter int unsigned MAX_MESSAGE = 1024
) (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [55:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              q_full,
  output logic              q_push,
  output arqst_pkg::cmd_t   q_cmd
);

  localparam logic [16:0] MSG_CAP   = 17'(MAX_MESSAGE);
  localparam logic [3:0]  CHUNK_CAP = 4'(MAX_CHUNKS);
  localparam logic [8:0]  SLOT_CNT  = 9'(SLOTS);

  logic [arqst_pkg::SEQ_W-1:0]   seq;
  logic [arqst_pkg::LEN_W-1:0]   len_raw;
  logic [arqst_pkg::CHUNK_W-1:0] chunks_raw;

  assign seq        = s_tdata[7:0];
  assign len_raw    = s_tdata[50:40];
  assign chunks_raw = s_tdata[54:51];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_cmd.mode     = arqst_pkg::mode_t'(s_tuser);
    q_cmd.seq      = seq;
    q_cmd.in_table = ({1'b0, seq} < SLOT_CNT);
    q_cmd.handle   = s_tdata[39:8];
    // clamp to the largest message and chunk count the link can carry
    q_cmd.length = ({6'd0, len_raw} > MSG_CAP) ? MSG_CAP[10:0] : len_raw;
    q_cmd.chunks = (chunks_raw > CHUNK_CAP) ? CHUNK_CAP : chunks_raw;
  end

endmodule

@@ rtl/arqst_cmdq.sv @@
// Two-entry command queue between the front and the back.
module arqst_cmdq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  arqst_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output arqst_pkg::cmd_t head
);

  arqst_pkg::cmd_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

@@ rtl/arqst_back.sv @@
// Execution side: slot memory, valid bits, occupancy and result sequencing.
`include "arq_retransmit_slot_table_unit_macros.svh"

module arqst_back #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  arqst_pkg::cmd_t                q_cmd,
  output logic                           q_pop,
  input  logic [arqst_pkg::OCC_W-1:0]    occ_limit,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output arqst_pkg::res_t                m_res
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  arqst_pkg::back_state_t state, state_next;
  arqst_pkg::cmd_t        cmd;
  arqst_pkg::entry_t      mem [SLOTS];
  arqst_pkg::entry_t      rd;
  arqst_pkg::entry_t      mem_wdata;
  arqst_pkg::res_t        res;

  logic [SLOTS-1:0]                valid_bits;
  logic [arqst_pkg::OCC_W-1:0]     occupancy, occ_next, occ_tmp;
  logic [arqst_pkg::CHUNK_W-1:0]   cnt, cnt_next, cnt_end, cnt_end_next;
  logic [arqst_pkg::CHUNK_W-1:0]   rem_new;
  logic                            hit_r, hit_next;
  logic [IDX_W-1:0]                idx;
  logic [IDX_W-1:0]                ridx;
  logic                            slot_hit;
  logic                            out_free;
  logic                            res_load;
  logic                            mem_we;
  logic                            valid_set, valid_clr, clr_all;
  logic                            emit_last;

  assign idx       = cmd.seq[IDX_W-1:0];
  assign ridx      = q_cmd.seq[IDX_W-1:0];
  assign slot_hit  = cmd.in_table && valid_bits[idx];
  assign out_free  = !m_tvalid || m_tready;
  assign emit_last = ((cnt + 4'd1) == cnt_end);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      arqst_pkg::ST_IDLE: begin
        if (q_valid) state_next = arqst_pkg::ST_EXEC;
      end
      arqst_pkg::ST_EXEC: begin
        if (out_free) begin
          if (cmd.mode == arqst_pkg::MODE_RETX && !(slot_hit && rd.total == '0)) begin
            state_next = arqst_pkg::ST_EMIT;
          end else begin
            state_next = arqst_pkg::ST_IDLE;
          end
        end
      end
      arqst_pkg::ST_EMIT: begin
        if (out_free && emit_last) state_next = arqst_pkg::ST_IDLE;
      end
      default: state_next = arqst_pkg::ST_IDLE;
    endcase
  end

  // outputs and updates
  always_comb begin
    q_pop        = 1'b0;
    res_load     = 1'b0;
    res          = '0;
    mem_we       = 1'b0;
    mem_wdata    = rd;
    valid_set    = 1'b0;
    valid_clr    = 1'b0;
    clr_all      = 1'b0;
    occ_next     = occupancy;
    occ_tmp      = occupancy;
    cnt_next     = cnt;
    cnt_end_next = cnt_end;
    hit_next     = hit_r;
    rem_new      = (rd.remaining != '0) ? rd.remaining - 4'd1 : rd.remaining;
    unique case (state)
      arqst_pkg::ST_IDLE: begin
        q_pop = q_valid;
      end
      arqst_pkg::ST_EXEC: begin
        if (out_free) begin
          res_load = 1'b1;
          res.kind = arqst_pkg::KIND_STATUS;
          res.last = 1'b1;
          case (cmd.mode)
            arqst_pkg::MODE_INSERT: begin
              if (cmd.in_table) begin
                mem_we           = 1'b1;
                mem_wdata.handle    = cmd.handle;
                mem_wdata.length    = cmd.length;
                mem_wdata.remaining = cmd.chunks;
                mem_wdata.total     = cmd.chunks;
                valid_set        = 1'b1;
                // a replaced entry is counted out before the new one is counted
                occ_tmp          = slot_hit ? arqst_pkg::occ_dec(occupancy) : occupancy;
                occ_next         = arqst_pkg::occ_inc(occ_tmp);
              end
            end
            arqst_pkg::MODE_ACK: begin
              res.hit = slot_hit;
              if (slot_hit) begin
                if (rem_new == '0) begin
                  valid_clr = 1'b1;
                  occ_next  = arqst_pkg::occ_dec(occupancy);
                  res.freed = 1'b1;
                end else begin
                  mem_we              = 1'b1;
                  mem_wdata.remaining = rem_new;
                end
              end
            end
            arqst_pkg::MODE_RETX: begin
              hit_next = slot_hit;
              if (slot_hit) begin
                res.kind     = arqst_pkg::KIND_RESEND;
                res.hit      = 1'b1;
                res.freed    = 1'b1;
                res.handle   = rd.handle;
                res.length   = rd.length;
                res.last     = (rd.total == '0);
                valid_clr    = 1'b1;
                occ_next     = arqst_pkg::occ_dec(occupancy);
                cnt_next     = '0;
                cnt_end_next = rd.total;
              end else begin
                // first clear of the miss run goes out here
                res.kind      = arqst_pkg::KIND_CLEAR;
                res.chunk_seq = cmd.seq;
                res.last      = (arqst_pkg::MISS_CLEARS == 4'd1);
                cnt_next      = 4'd1;
                cnt_end_next  = arqst_pkg::MISS_CLEARS;
              end
            end
            arqst_pkg::MODE_CLEAR: begin
              clr_all  = 1'b1;
              occ_next = '0;
            end
            default: ;
          endcase
          res.room = (occ_next < occ_limit);
        end
      end
      arqst_pkg::ST_EMIT: begin
        if (out_free) begin
          res_load      = 1'b1;
          res.kind      = arqst_pkg::KIND_CLEAR;
          res.hit       = hit_r;
          res.freed     = hit_r;
          res.chunk_seq = cmd.seq + {4'd0, cnt};
          res.room      = (occupancy < occ_limit);
          res.last      = emit_last;
          cnt_next      = cnt + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= arqst_pkg::ST_IDLE;
      occupancy  <= '0;
      valid_bits <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occ_next;
      if (clr_all) begin
        valid_bits <= '0;
      end else if (valid_set) begin
        valid_bits[idx] <= 1'b1;
      end else if (valid_clr) begin
        valid_bits[idx] <= 1'b0;
      end
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
    if (res_load) m_res <= res;
    cnt     <= cnt_next;
    cnt_end <= cnt_end_next;
    hit_r   <= hit_next;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[idx] <= mem_wdata;
    if (q_pop) rd <= mem[ridx];
  end

  `ARQST_ASSERT_IMPLIES(a_occ_matches_valid, 1'b1, 32'(occupancy) == $countones(valid_bits))
  `ARQST_ASSERT_IMPLIES(a_emit_in_range, state == arqst_pkg::ST_EMIT, cnt < cnt_end)
  `ARQST_ASSERT_NEXT(a_last_ends_item, res_load && res.last, state == arqst_pkg::ST_IDLE)
  `ARQST_ASSERT_NEXT(a_free_counts_out, res_load && valid_clr, occupancy == $past(occupancy) - 9'd1)

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the ARQ retransmit slot table: stream traffic, APB limit writes.
`timescale 1ns / 1ps

// Scoreboard: mirrors the slot table and the occupancy count, and turns every
// accepted event into the run of results the block should send back.
class slot_table_scoreboard;
  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned CHUNK_CAP  = 8;
  localparam int unsigned LENGTH_CAP = 1024;

  bit          slot_used[TABLE_SIZE];
  logic [31:0] slot_buf[TABLE_SIZE];
  logic [10:0] slot_len[TABLE_SIZE];
  logic [3:0]  slot_left[TABLE_SIZE];
  logic [3:0]  slot_chunks[TABLE_SIZE];
  logic [8:0]  occ;
  logic [8:0]  limit;

  arqst_pkg::res_t expected_results[$];
  int              mismatches;
  int              results_seen;
  int              mode_count[4];

  function new();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    occ   = '0;
    limit = arqst_pkg::OCC_LIMIT_RESET;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void set_limit(logic [8:0] value);
    limit = value;
  endfunction

  function void release_one();
    if (occ != '0) occ--;
  endfunction

  function void add_result(arqst_pkg::kind_t kind, bit hit, bit freed, logic [31:0] handle,
                           logic [10:0] len, logic [7:0] cseq);
    arqst_pkg::res_t r;
    r.kind      = kind;
    r.hit       = hit;
    r.freed     = freed;
    r.handle    = handle;
    r.length    = len;
    r.chunk_seq = cseq;
    r.room      = 1'b0;
    r.last      = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Update the table for one accepted event and queue its results.
  function void note_event(arqst_pkg::mode_t mode, logic [7:0] seq, logic [31:0] handle,
                           logic [10:0] len, logic [3:0] chunks);
    int         first;
    int         i;
    bit         hit;
    bit         freed;
    logic [3:0] total;
    first = expected_results.size();
    hit   = slot_used[seq];
    freed = 1'b0;
    mode_count[mode]++;
    case (mode)
      arqst_pkg::MODE_INSERT: begin
        // Overwrite: count the old entry out before the new one comes in.
        if (slot_used[seq]) begin
          slot_used[seq] = 1'b0;
          release_one();
        end
        slot_buf[seq]    = handle;
        slot_len[seq]    = (len > LENGTH_CAP) ? 11'(LENGTH_CAP) : len;
        slot_left[seq]   = (chunks > CHUNK_CAP) ? 4'(CHUNK_CAP) : chunks;
        slot_chunks[seq] = slot_left[seq];
        slot_used[seq]   = 1'b1;
        if (occ != arqst_pkg::OCC_MAX) occ++;
        add_result(arqst_pkg::KIND_STATUS, 1'b0, 1'b0, '0, '0, '0);
      end
      arqst_pkg::MODE_ACK: begin
        if (hit) begin
          if (slot_left[seq] != '0) slot_left[seq]--;
          if (slot_left[seq] == '0) begin
            slot_used[seq]   = 1'b0;
            slot_chunks[seq] = '0;
            release_one();
            freed = 1'b1;
          end
        end
        add_result(arqst_pkg::KIND_STATUS, hit, freed, '0, '0, '0);
      end
      arqst_pkg::MODE_RETX: begin
        if (hit) begin
          total = slot_chunks[seq];
          add_result(arqst_pkg::KIND_RESEND, 1'b1, 1'b1, slot_buf[seq], slot_len[seq], '0);
          slot_used[seq]   = 1'b0;
          slot_chunks[seq] = '0;
          release_one();
          for (i = 0; i < int'(total); i++)
            add_result(arqst_pkg::KIND_CLEAR, 1'b1, 1'b1, '0, '0, 8'(seq + i));
        end else begin
          for (i = 0; i < int'(arqst_pkg::MISS_CLEARS); i++)
            add_result(arqst_pkg::KIND_CLEAR, 1'b0, 1'b0, '0, '0, 8'(seq + i));
        end
      end
      default: begin
        foreach (slot_used[j]) slot_used[j] = 1'b0;
        occ = '0;
        add_result(arqst_pkg::KIND_STATUS, 1'b0, 1'b0, '0, '0, '0);
      end
    endcase
    // Room is judged after the event; the final result of the run carries last.
    for (i = first; i < expected_results.size(); i++) begin
      expected_results[i].room = (occ < limit);
      expected_results[i].last = (i == expected_results.size() - 1);
    end
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
  endtask

  // Compare one accepted result with the oldest expectation.
  task check_result(logic [1:0] kind, logic [55:0] data, logic last);
    arqst_pkg::res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result kind %0d arrived with nothing expected", kind));
      return;
    end
    want = expected_results.pop_front();
    results_seen++;
    compare_field("kind", 32'(kind), 32'(want.kind));
    compare_field("hit", 32'(data[0]), 32'(want.hit));
    compare_field("freed", 32'(data[1]), 32'(want.freed));
    compare_field("resend_handle", data[33:2], want.handle);
    compare_field("resend_length", 32'(data[44:34]), 32'(want.length));
    compare_field("chunk_seq", 32'(data[52:45]), 32'(want.chunk_seq));
    compare_field("room_available", 32'(data[53]), 32'(want.room));
    compare_field("last", 32'(last), 32'(want.last));
  endtask
endclass

module testbench;
  // APB byte address of the occupancy limit register.
  localparam logic [2:0] OCC_LIMIT_ADDR = {arqst_pkg::REG_OCC_LIMIT, 2'b00};

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // seq[7:0], buffer_handle[39:8], length[50:40], chunk_count[54:51], zero[55]
  logic [55:0] s_axis_tdata;
  // mode[1:0]
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // hit[0], freed[1], resend_handle[33:2], resend_length[44:34],
  // chunk_seq[52:45], room_available[53], zero[55:54]
  logic [55:0] m_axis_tdata;
  // kind[1:0]
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // When set, neither side idles: gives a long back-to-back stretch.
  bit steady;

  slot_table_scoreboard sb;

  arq_retransmit_slot_table_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: stall at random on the falling edge, check on the rising edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = steady || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // Offer one event and hold it until the block takes it. Called at a falling
  // edge; returns at the falling edge after acceptance with tvalid still high,
  // so a following event goes out back to back.
  task send_event(arqst_pkg::mode_t mode, logic [7:0] seq, logic [31:0] handle,
                  logic [10:0] len, logic [3:0] chunks);
    while (!steady && $urandom_range(99) < 31) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = mode;
    s_axis_tdata  = {1'b0, chunks, len, handle, seq};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_event(mode, seq, handle, len, chunks);
    @(negedge clk);
  endtask

  // Drop tvalid and hold off until every queued result has come back.
  task wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // APB write of the occupancy limit, setup then access phase; only called with the block idle.
  task write_limit(logic [8:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = OCC_LIMIT_ADDR;
    pwdata  = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_limit(value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Random traffic around a window of eight sequence numbers, so that inserts,
  // acknowledges and retransmits keep hitting live slots; a tenth of the items
  // land anywhere in the table and a few carry out-of-range lengths or counts.
  task run_traffic(int count, logic [7:0] base);
    arqst_pkg::mode_t mode;
    logic [7:0]       seq;
    logic [10:0]      len;
    logic [3:0]       chunks;
    int               pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 40)      mode = arqst_pkg::MODE_INSERT;
      else if (pick < 70) mode = arqst_pkg::MODE_ACK;
      else if (pick < 96) mode = arqst_pkg::MODE_RETX;
      else                mode = arqst_pkg::MODE_CLEAR;
      if ($urandom_range(9) == 0) seq = 8'($urandom_range(255));
      else                        seq = base + 8'($urandom_range(7));
      if ($urandom_range(99) < 85) len = 11'($urandom_range(1024));
      else                         len = 11'($urandom_range(2047, 1025));
      if ($urandom_range(99) < 80) chunks = 4'($urandom_range(8, 1));
      else                         chunks = 4'($urandom_range(15));
      send_event(mode, seq, $urandom, len, chunks);
    end
  endtask

  initial begin
    sb            = new();
    steady        = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, limit at its reset value.
    // Misses on an empty table; the retransmit miss wraps chunk_seq past 255.
    send_event(arqst_pkg::MODE_ACK, 8'd0, '0, '0, '0);
    send_event(arqst_pkg::MODE_RETX, 8'd250, '0, '0, '0);
    // All-ones fields: length and chunk count saturate on insert.
    send_event(arqst_pkg::MODE_INSERT, 8'd0, 32'hFFFF_FFFF, 11'h7FF, 4'hF);
    // All-zeros content at the top slot: zero chunks, freed by the first ack.
    send_event(arqst_pkg::MODE_INSERT, 8'd255, 32'h0, 11'd0, 4'd0);
    send_event(arqst_pkg::MODE_ACK, 8'd255, '0, '0, '0);
    // Overwrite a live slot, then count it down to free and miss afterwards.
    send_event(arqst_pkg::MODE_INSERT, 8'd1, 32'hA5A5_A5A5, 11'd1024, 4'd8);
    send_event(arqst_pkg::MODE_INSERT, 8'd1, 32'h5A5A_5A5A, 11'd1, 4'd2);
    send_event(arqst_pkg::MODE_ACK, 8'd1, '0, '0, '0);
    send_event(arqst_pkg::MODE_ACK, 8'd1, '0, '0, '0);
    send_event(arqst_pkg::MODE_ACK, 8'd1, '0, '0, '0);
    // Retransmit hits: full chunk run, a single chunk, and no chunks at all.
    send_event(arqst_pkg::MODE_RETX, 8'd0, '0, '0, '0);
    send_event(arqst_pkg::MODE_INSERT, 8'd7, 32'h1234_5678, 11'd1023, 4'd1);
    send_event(arqst_pkg::MODE_RETX, 8'd7, '0, '0, '0);
    send_event(arqst_pkg::MODE_INSERT, 8'd9, 32'h8000_0001, 11'd512, 4'd0);
    send_event(arqst_pkg::MODE_RETX, 8'd9, '0, '0, '0);
    // Clear all empties the table; the next ack misses.
    send_event(arqst_pkg::MODE_INSERT, 8'd2, 32'hDEAD_BEEF, 11'd100, 4'd3);
    send_event(arqst_pkg::MODE_INSERT, 8'd3, 32'h0BAD_F00D, 11'd200, 4'd4);
    send_event(arqst_pkg::MODE_CLEAR, 8'd2, '0, '0, '0);
    send_event(arqst_pkg::MODE_ACK, 8'd2, '0, '0, '0);
    run_traffic(25, 8'($urandom_range(255)));

    // Limit zero: room is never reported.
    wait_drained();
    write_limit(9'd0);
    run_traffic(20, 8'($urandom_range(255)));

    // Small limit toggles room with the occupancy; run this phase without idling.
    wait_drained();
    write_limit(9'd3);
    steady = 1'b1;
    run_traffic(30, 8'($urandom_range(255)));
    steady = 1'b0;

    // Full-table limit.
    wait_drained();
    write_limit(9'd256);
    run_traffic(25, 8'($urandom_range(255)));

    wait_drained();
    repeat (20) @(negedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Covered %0d inserts, %0d acks, %0d retransmits, %0d clear-alls;",
             sb.mode_count[arqst_pkg::MODE_INSERT], sb.mode_count[arqst_pkg::MODE_ACK],
             sb.mode_count[arqst_pkg::MODE_RETX], sb.mode_count[arqst_pkg::MODE_CLEAR]);
    $display("%0d results checked; occupancy limits exercised: 240 (reset), 0, 3, 256",
             sb.results_seen);
    if (sb.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #100000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/arqst_pkg.sv
rtl/arqst_front.sv
rtl/arqst_cmdq.sv
rtl/arqst_back.sv
rtl/arq_retransmit_slot_table_unit.sv
test/testbench.sv
